>>> rtl/core/ri2p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ri2p_pkg
// Shared types and codes for the regex infix-to-postfix converter.
// ----------------------------------------------------------------------------
package ri2p_pkg;

	localparam int KIND_W = 3;
	localparam int LIT_W  = 8;
	localparam int POS_W  = 16;
	localparam int ERR_W  = 2;

	// token kinds
	localparam logic [KIND_W-1:0] K_LIT  = 3'd0;
	localparam logic [KIND_W-1:0] K_STAR = 3'd1;
	localparam logic [KIND_W-1:0] K_CAT  = 3'd2;
	localparam logic [KIND_W-1:0] K_OR   = 3'd3;
	localparam logic [KIND_W-1:0] K_LPAR = 3'd4;
	localparam logic [KIND_W-1:0] K_RPAR = 3'd5;

	// error codes
	localparam logic [ERR_W-1:0] E_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] E_UNM_RPAR = 2'd1;
	localparam logic [ERR_W-1:0] E_UNM_LPAR = 2'd2;
	localparam logic [ERR_W-1:0] E_OVERFLOW = 2'd3;

	// operator precedence
	localparam logic [1:0] PREC_STAR = 2'd3;
	localparam logic [1:0] PREC_CAT  = 2'd2;
	localparam logic [1:0] PREC_OR   = 2'd1;
	localparam logic [1:0] PREC_NONE = 2'd0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [LIT_W-1:0]  literal;
		logic [POS_W-1:0]  position;
		logic              expr_end;
	} token_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [KIND_W-1:0] kind;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [LIT_W-1:0]  literal;
		logic [POS_W-1:0]  position;
		logic              present;
		logic [ERR_W-1:0]  err;
		logic              done;
		logic              last;
	} result_t;

	function automatic logic [1:0] prec_of(input logic [KIND_W-1:0] kind);
		logic [1:0] p;
		case (kind)
			K_STAR:  p = PREC_STAR;
			K_CAT:   p = PREC_CAT;
			K_OR:    p = PREC_OR;
			default: p = PREC_NONE;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/ri2p_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ri2p_if
// Valid/ready channels: token requests in, postfix result requests out.
// ----------------------------------------------------------------------------
interface ri2p_token_if import ri2p_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] token_kind;
	logic [LIT_W-1:0]  literal_byte;
	logic [POS_W-1:0]  source_position;
	logic              expression_end;

	modport source (output valid, token_kind, literal_byte, source_position, expression_end,
		input ready);
	modport sink (input valid, token_kind, literal_byte, source_position, expression_end,
		output ready);
endinterface

interface ri2p_result_if import ri2p_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] emitted_kind;
	logic [LIT_W-1:0]  emitted_literal;
	logic [POS_W-1:0]  emitted_position;
	logic              token_present;
	logic [ERR_W-1:0]  error_code;
	logic              expression_done;
	logic              run_last;

	modport source (output valid, emitted_kind, emitted_literal, emitted_position,
		token_present, error_code, expression_done, run_last, input ready);
	modport sink (input valid, emitted_kind, emitted_literal, emitted_position,
		token_present, error_code, expression_done, run_last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ri2p_stack_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ri2p_stack_mem
// Operator stack storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ri2p_stack_mem import ri2p_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire          clk,
	input  wire          we,
	input  wire [AW-1:0] waddr,
	input  entry_t       wdata,
	input  wire          re,
	input  wire [AW-1:0] raddr,
	output entry_t       rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/ri2p_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ri2p_out_reg
// Result output register; decouples the sequencer from the result sink.
// ----------------------------------------------------------------------------
module ri2p_out_reg import ri2p_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            load,
	input  result_t        din,
	output logic           free,
	ri2p_result_if.source  results
);

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign results.valid            = valid_q;
	assign results.emitted_kind     = data_q.kind;
	assign results.emitted_literal  = data_q.literal;
	assign results.emitted_position = data_q.position;
	assign results.token_present    = data_q.present;
	assign results.error_code       = data_q.err;
	assign results.expression_done  = data_q.done;
	assign results.run_last         = data_q.last;

endmodule
`default_nettype wire

>>> rtl/core/regex_infix_to_postfix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// regex_infix_to_postfix
// Shunting-yard conversion of regex tokens to postfix order.
// ----------------------------------------------------------------------------
// Flow: a token is registered when taken and handled in S_PROC once the
//   output register is free; results leave via a one-entry output register.
//   One stack read per cycle. A token is taken only in S_IDLE, after the last
//   is done; popped operators, an end flush (via S_LOAD after a push) and a
//   closing result behind a held one (S_FIN) add steps; output stalls wait.
// Reset: stack count, skip flag and pending result cleared; stack not cleared.
// ----------------------------------------------------------------------------
module regex_infix_to_postfix import ri2p_pkg::*; #(
	parameter int STACK_DEPTH = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	ri2p_token_if.sink    tokens,
	ri2p_result_if.source results
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0; // waiting for a token request
	localparam logic [2:0] S_PROC  = 3'd1; // token in hand, stack top valid
	localparam logic [2:0] S_LOAD  = 3'd2; // read new top after a push
	localparam logic [2:0] S_FLUSH = 3'd3; // end of expression: drain stack
	localparam logic [2:0] S_FIN   = 3'd4; // send held result as the last one

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          skip_q, skip_d;
	token_t        tok_q;

	// One result is held back so that run_last can be set on it once we
	// know nothing follows.
	result_t       pend_q, pend_d;
	logic          pend_vld_q, pend_vld_d;

	// stack memory
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, top;

	// output register
	logic          out_load, out_free;
	result_t       out_din;

	// step requests to the common result logic
	logic          prod_en, prod_final, fin_en;
	result_t       prod_r;

	logic [CW-1:0] cnt_m1, cnt_m2;
	logic          have_top, stack_full, accept;

	assign cnt_m1     = cnt_q - CW'(1);
	assign cnt_m2     = cnt_q - CW'(2);
	assign have_top   = cnt_q != '0;
	assign stack_full = cnt_q >= CW'(STACK_DEPTH);

	assign tokens.ready = state_q == S_IDLE;
	assign accept       = tokens.valid && tokens.ready;

	ri2p_stack_mem #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (top)
	);

	ri2p_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (out_load),
		.din     (out_din),
		.free    (out_free),
		.results (results)
	);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		skip_d     = skip_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;

		mem_we     = 1'b0;
		mem_waddr  = cnt_q[AW-1:0];
		mem_wdata  = '{position: tok_q.position, kind: tok_q.kind};
		mem_re     = 1'b0;
		mem_raddr  = cnt_m1[AW-1:0];

		out_load   = 1'b0;
		out_din    = pend_q;

		prod_en    = 1'b0;
		prod_final = 1'b0;
		prod_r     = '0;
		fin_en     = 1'b0;

		case (state_q)
			S_IDLE: begin
				// fetch the stack top alongside the token
				if (accept) begin
					mem_re  = have_top;
					state_d = S_PROC;
				end
			end

			S_PROC: begin
				if (out_free) begin
					if (skip_q) begin
						// discard tokens until the end of the broken expression
						if (tok_q.expr_end) begin
							skip_d     = 1'b0;
							cnt_d      = '0;
							prod_en    = 1'b1;
							prod_final = 1'b1;
						end else begin
							fin_en = 1'b1;
						end
					end else begin
						case (tok_q.kind)
							K_LIT: begin
								prod_en         = 1'b1;
								prod_r.kind     = K_LIT;
								prod_r.literal  = tok_q.literal;
								prod_r.position = tok_q.position;
								prod_r.present  = 1'b1;
								if (tok_q.expr_end && have_top) begin
									state_d = S_FLUSH;
								end else begin
									prod_final = 1'b1;
								end
							end
							K_STAR, K_CAT, K_OR: begin
								if (have_top && prec_of(top.kind) != PREC_NONE &&
										prec_of(top.kind) >= prec_of(tok_q.kind)) begin
									// pop higher/equal precedence operator, read next
									prod_en         = 1'b1;
									prod_r.kind     = top.kind;
									prod_r.position = top.position;
									prod_r.present  = 1'b1;
									cnt_d           = cnt_m1;
									mem_re          = cnt_q > CW'(1);
									mem_raddr       = cnt_m2[AW-1:0];
								end else if (stack_full) begin
									prod_en         = 1'b1;
									prod_final      = 1'b1;
									prod_r.position = tok_q.position;
									prod_r.err      = E_OVERFLOW;
									cnt_d           = '0;
									skip_d          = !tok_q.expr_end;
								end else begin
									mem_we = 1'b1;
									cnt_d  = cnt_q + CW'(1);
									if (tok_q.expr_end) begin
										state_d = S_LOAD;
									end else begin
										fin_en = 1'b1;
									end
								end
							end
							K_LPAR: begin
								if (stack_full) begin
									prod_en         = 1'b1;
									prod_final      = 1'b1;
									prod_r.position = tok_q.position;
									prod_r.err      = E_OVERFLOW;
									cnt_d           = '0;
									skip_d          = !tok_q.expr_end;
								end else begin
									mem_we = 1'b1;
									cnt_d  = cnt_q + CW'(1);
									if (tok_q.expr_end) begin
										state_d = S_LOAD;
									end else begin
										fin_en = 1'b1;
									end
								end
							end
							K_RPAR: begin
								if (have_top && top.kind != K_LPAR) begin
									prod_en         = 1'b1;
									prod_r.kind     = top.kind;
									prod_r.position = top.position;
									prod_r.present  = 1'b1;
									cnt_d           = cnt_m1;
									mem_re          = cnt_q > CW'(1);
									mem_raddr       = cnt_m2[AW-1:0];
								end else if (have_top) begin
									// drop the matching open paren
									cnt_d     = cnt_m1;
									mem_re    = cnt_q > CW'(1);
									mem_raddr = cnt_m2[AW-1:0];
									if (tok_q.expr_end) begin
										state_d = S_FLUSH;
									end else begin
										fin_en = 1'b1;
									end
								end else begin
									prod_en         = 1'b1;
									prod_final      = 1'b1;
									prod_r.position = tok_q.position;
									prod_r.err      = E_UNM_RPAR;
									cnt_d           = '0;
									skip_d          = !tok_q.expr_end;
								end
							end
							default: begin
								// unused kind codes: only the end flag acts
								if (tok_q.expr_end) begin
									state_d = S_FLUSH;
								end else begin
									fin_en = 1'b1;
								end
							end
						endcase
					end
				end
			end

			S_LOAD: begin
				mem_re  = 1'b1;
				state_d = S_FLUSH;
			end

			S_FLUSH: begin
				if (out_free) begin
					if (!have_top) begin
						fin_en = 1'b1;
					end else if (top.kind == K_LPAR) begin
						// open paren left over at the end
						prod_en         = 1'b1;
						prod_final      = 1'b1;
						prod_r.position = top.position;
						prod_r.err      = E_UNM_LPAR;
						cnt_d           = '0;
					end else begin
						prod_en         = 1'b1;
						prod_r.kind     = top.kind;
						prod_r.position = top.position;
						prod_r.present  = 1'b1;
						cnt_d           = cnt_m1;
						mem_re          = cnt_q > CW'(1);
						mem_raddr       = cnt_m2[AW-1:0];
					end
				end
			end

			S_FIN: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_din.last  = 1'b1;
					out_din.done  = tok_q.expr_end;
					pend_vld_d    = 1'b0;
					state_d       = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// New result: the held one goes out, the new one is held, unless it
		// closes the run and nothing is held, in which case it goes straight out.
		if (prod_en) begin
			if (pend_vld_q) begin
				out_load   = 1'b1;
				out_din    = pend_q;
				pend_d     = prod_r;
				pend_vld_d = 1'b1;
				if (prod_final) begin
					state_d = S_FIN;
				end
			end else if (prod_final) begin
				out_load     = 1'b1;
				out_din      = prod_r;
				out_din.last = 1'b1;
				out_din.done = tok_q.expr_end;
				state_d      = S_IDLE;
			end else begin
				pend_d     = prod_r;
				pend_vld_d = 1'b1;
			end
		end

		// Run ends with no new result: release the held one, or send the
		// end marker if an expression ends with nothing to show.
		if (fin_en) begin
			state_d = S_IDLE;
			if (pend_vld_q) begin
				out_load     = 1'b1;
				out_din      = pend_q;
				out_din.last = 1'b1;
				out_din.done = tok_q.expr_end;
				pend_vld_d   = 1'b0;
			end else if (tok_q.expr_end) begin
				out_load     = 1'b1;
				out_din      = '0;
				out_din.last = 1'b1;
				out_din.done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			skip_q     <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			skip_q     <= skip_d;
			pend_vld_q <= pend_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (accept) begin
			tok_q.kind     <= tokens.token_kind;
			tok_q.literal  <= tokens.literal_byte;
			tok_q.position <= tokens.source_position;
			tok_q.expr_end <= tokens.expression_end;
		end
	end

endmodule
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the regex infix-to-postfix converter. Token requests
// go in on a valid/ready channel; a built-in shunting-yard predictor queues the
// expected postfix result requests; each accepted result is checked in order.
// ----------------------------------------------------------------------------
module tb;
	import ri2p_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 32;

	logic clk;
	logic arst_n;

	ri2p_token_if  tok_ch ();
	ri2p_result_if res_ch ();

	regex_infix_to_postfix #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tokens  (tok_ch),
		.results (res_ch)
	);

	always #5 clk = ~clk;

	// idle rates in percent, changed between phases
	int src_idle_pct;
	int snk_idle_pct;
	// cycles the result sink still has to hold off
	int hold_left;

	int mismatches;
	int tokens_sent;

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the operator stack
	// ------------------------------------------------------------------------
	entry_t  op_stack [STACK_DEPTH];
	int      stack_fill;
	bit      skip_mode;
	result_t postfix_q [$];

	// scratch for generated token sequences
	token_t  expr_buf [$];

	// binding strength of an operator; zero for anything else
	function automatic int op_rank(input logic [KIND_W-1:0] kind);
		case (kind)
			K_STAR:  return 3;
			K_CAT:   return 2;
			K_OR:    return 1;
			default: return 0;
		endcase
	endfunction

	function automatic result_t stack_result(input entry_t e);
		result_t r;
		r = '0;
		r.kind = e.kind;
		r.position = e.position;
		r.present = 1'b1;
		return r;
	endfunction

	// returns 0 when the stack is already full
	function automatic bit push_op(input token_t t);
		if (stack_fill >= STACK_DEPTH)
			return 1'b0;
		op_stack[stack_fill].kind = t.kind;
		op_stack[stack_fill].position = t.position;
		stack_fill++;
		return 1'b1;
	endfunction

	// Works out every result one accepted token causes and queues them.
	function automatic void shunt_token(input token_t t);
		result_t          run [$];
		result_t          r;
		entry_t           e;
		logic [ERR_W-1:0] err;
		err = E_NONE;
		// after an error, everything up to the end flag is dropped
		if (skip_mode) begin
			if (t.expr_end) begin
				skip_mode = 1'b0;
				stack_fill = 0;
				r = '0;
				r.done = 1'b1;
				r.last = 1'b1;
				postfix_q.push_back(r);
			end
			return;
		end
		case (t.kind)
			K_LIT: begin
				r = '0;
				r.kind = K_LIT;
				r.literal = t.literal;
				r.position = t.position;
				r.present = 1'b1;
				run.push_back(r);
			end
			K_STAR, K_CAT, K_OR: begin
				// pop anything that binds at least as tightly (left-assoc)
				while (stack_fill > 0 && op_rank(op_stack[stack_fill-1].kind) > 0 &&
						op_rank(op_stack[stack_fill-1].kind) >= op_rank(t.kind)) begin
					stack_fill--;
					run.push_back(stack_result(op_stack[stack_fill]));
				end
				if (!push_op(t))
					err = E_OVERFLOW;
			end
			K_LPAR: begin
				if (!push_op(t))
					err = E_OVERFLOW;
			end
			K_RPAR: begin
				while (stack_fill > 0 && op_stack[stack_fill-1].kind != K_LPAR) begin
					stack_fill--;
					run.push_back(stack_result(op_stack[stack_fill]));
				end
				if (stack_fill > 0)
					stack_fill--;
				else
					err = E_UNM_RPAR;
			end
			default: ; // unknown kinds do nothing, end flag still acts
		endcase
		if (err != E_NONE) begin
			r = '0;
			r.position = t.position;
			r.err = err;
			run.push_back(r);
			stack_fill = 0;
			if (!t.expr_end)
				skip_mode = 1'b1;
		end else if (t.expr_end) begin
			// flush; a leftover open paren ends the flush with an error
			while (stack_fill > 0) begin
				stack_fill--;
				e = op_stack[stack_fill];
				if (e.kind == K_LPAR) begin
					r = '0;
					r.position = e.position;
					r.err = E_UNM_LPAR;
					run.push_back(r);
					stack_fill = 0;
					break;
				end
				run.push_back(stack_result(e));
			end
		end
		// an end token always yields at least a bare end marker
		if (t.expr_end && run.size() == 0) begin
			r = '0;
			run.push_back(r);
		end
		if (run.size() > 0) begin
			run[$].last = 1'b1;
			if (t.expr_end)
				run[$].done = 1'b1;
		end
		foreach (run[i])
			postfix_q.push_back(run[i]);
	endfunction

	function automatic token_t mk(input logic [KIND_W-1:0] kind, input logic [LIT_W-1:0] lit,
			input logic [POS_W-1:0] pos, input logic last_tok);
		token_t t;
		t.kind = kind;
		t.literal = lit;
		t.position = pos;
		t.expr_end = last_tok;
		return t;
	endfunction

	// ------------------------------------------------------------------------
	// Token request driver: changes inputs at the falling edge, sees the
	// handshake at the rising edge. Valid stays high between back-to-back
	// requests; it only drops for an idle gap or at drop_valid.
	// ------------------------------------------------------------------------
	task automatic send_token(input token_t t);
		@(negedge clk);
		// each cycle is an idle one with the sender's idle probability
		while ($urandom_range(99) < src_idle_pct) begin
			tok_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tok_ch.valid           <= 1'b1;
		tok_ch.token_kind      <= t.kind;
		tok_ch.literal_byte    <= t.literal;
		tok_ch.source_position <= t.position;
		tok_ch.expression_end  <= t.expr_end;
		do
			@(posedge clk);
		while (tok_ch.ready !== 1'b1);
		shunt_token(t);
		tokens_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		tok_ch.valid <= 1'b0;
	endtask

	task automatic send_buf();
		foreach (expr_buf[i])
			send_token(expr_buf[i]);
	endtask

	// appends a token at the next source position
	task automatic add_tok(input logic [KIND_W-1:0] kind, inout logic [POS_W-1:0] pos);
		expr_buf.push_back(mk(kind, LIT_W'($urandom_range(255)), pos, 1'b0));
		pos++;
	endtask

	// Builds a well-formed infix expression with explicit concatenation
	// tokens. Alternates between wanting an operand and having one.
	task automatic build_expression(input int target_len, input int max_nest);
		int             open_cnt;
		bit             want_operand;
		logic [POS_W-1:0] pos;
		expr_buf.delete();
		open_cnt = 0;
		want_operand = 1'b1;
		pos = POS_W'($urandom_range(65535));
		forever begin
			if (want_operand) begin
				if (open_cnt < max_nest && $urandom_range(4) == 0) begin
					add_tok(K_LPAR, pos);
					open_cnt++;
				end else begin
					add_tok(K_LIT, pos);
					want_operand = 1'b0;
				end
			end else if ($urandom_range(3) == 0) begin
				add_tok(K_STAR, pos);
			end else if (open_cnt > 0 &&
					(expr_buf.size() >= target_len || $urandom_range(3) == 0)) begin
				add_tok(K_RPAR, pos);
				open_cnt--;
			end else if (expr_buf.size() >= target_len) begin
				break;
			end else begin
				add_tok($urandom_range(1) ? K_CAT : K_OR, pos);
				want_operand = 1'b1;
			end
		end
		expr_buf[$].expr_end = 1'b1;
	endtask

	// Damages a built expression: drop, retype or insert a paren; the end
	// flag sometimes lands early so the tail runs into the next expression.
	task automatic break_expression();
		int idx;
		idx = $urandom_range(expr_buf.size() - 1);
		case ($urandom_range(2))
			0: if (expr_buf.size() > 1) expr_buf.delete(idx);
			1: expr_buf[idx].kind = KIND_W'($urandom_range(7));
			default: expr_buf.insert(idx, mk($urandom_range(1) ? K_LPAR : K_RPAR,
				LIT_W'($urandom_range(255)), POS_W'($urandom_range(65535)), 1'b0));
		endcase
		foreach (expr_buf[i])
			expr_buf[i].expr_end = 1'b0;
		if ($urandom_range(3) == 0)
			expr_buf[$urandom_range(expr_buf.size() - 1)].expr_end = 1'b1;
		else
			expr_buf[$].expr_end = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Field extremes, every kind, both paren errors and the end marker cases.
	task automatic test_directed_cases();
		// 0x00 . 0xFF * | ( a | b ) *  -- end on the last star
		send_token(mk(K_LIT,  8'h00, 16'h0000, 1'b0));
		send_token(mk(K_CAT,  8'hFF, 16'h0001, 1'b0));
		send_token(mk(K_LIT,  8'hFF, 16'hFFFF, 1'b0));
		send_token(mk(K_STAR, 8'h00, 16'h0002, 1'b0));
		send_token(mk(K_OR,   8'h5A, 16'h0003, 1'b0));
		send_token(mk(K_LPAR, 8'hA5, 16'h0004, 1'b0));
		send_token(mk(K_LIT,  8'h61, 16'h0005, 1'b0));
		send_token(mk(K_OR,   8'h00, 16'h0006, 1'b0));
		send_token(mk(K_LIT,  8'h62, 16'h0007, 1'b0));
		send_token(mk(K_RPAR, 8'h00, 16'h0008, 1'b0));
		send_token(mk(K_STAR, 8'h00, 16'hAAAA, 1'b1));
		// stray close paren mid-expression, rest skipped up to the end
		send_token(mk(K_RPAR, 8'h00, 16'h8000, 1'b0));
		send_token(mk(K_LIT,  8'h33, 16'h8001, 1'b0));
		send_token(mk(K_STAR, 8'h00, 16'h8002, 1'b1));
		// open paren left on the stack at the end flush
		send_token(mk(K_LPAR, 8'h00, 16'h1234, 1'b0));
		send_token(mk(K_LIT,  8'h78, 16'h1235, 1'b0));
		send_token(mk(K_CAT,  8'h00, 16'h1236, 1'b0));
		send_token(mk(K_LIT,  8'h79, 16'h1237, 1'b1));
		// unknown kinds; the second one still closes the expression
		send_token(mk(3'd6,   8'hFF, 16'h5555, 1'b0));
		send_token(mk(3'd7,   8'hFF, 16'hFFFF, 1'b1));
		// stray close paren on the end token itself
		send_token(mk(K_RPAR, 8'h00, 16'h7FFF, 1'b1));
		// lone operator flushed on its own
		send_token(mk(K_OR,   8'h00, 16'h0100, 1'b1));
		send_token(mk(K_LIT,  8'h80, 16'h0101, 1'b1));
		drop_valid();
	endtask

	// Nesting to the full stack depth, and one past it.
	task automatic test_deep_nesting();
		logic [POS_W-1:0] pos;
		pos = POS_W'($urandom_range(65535));
		// ( a | ( a | ... a ) ... )  -- fills all 32 entries, closes cleanly
		expr_buf.delete();
		repeat (STACK_DEPTH / 2) begin
			add_tok(K_LPAR, pos);
			add_tok(K_LIT, pos);
			add_tok(K_OR, pos);
		end
		add_tok(K_LIT, pos);
		repeat (STACK_DEPTH / 2)
			add_tok(K_RPAR, pos);
		expr_buf[$].expr_end = 1'b1;
		send_buf();
		// same fill, then a concatenation overflows; tail is skipped
		expr_buf.delete();
		repeat (STACK_DEPTH / 2) begin
			add_tok(K_LPAR, pos);
			add_tok(K_LIT, pos);
			add_tok(K_OR, pos);
		end
		add_tok(K_LIT, pos);
		add_tok(K_CAT, pos);
		add_tok(K_LIT, pos);
		add_tok(K_LIT, pos);
		expr_buf[$].expr_end = 1'b1;
		send_buf();
		// open parens only; the one past the limit carries the end flag
		expr_buf.delete();
		repeat (STACK_DEPTH + 1)
			add_tok(K_LPAR, pos);
		expr_buf[$].expr_end = 1'b1;
		send_buf();
		drop_valid();
	endtask

	// Sink holds off for a long stretch while a long chain keeps coming,
	// so the block's output fills and it has to stall token requests.
	task automatic test_backpressure();
		logic [POS_W-1:0] pos;
		pos = POS_W'($urandom_range(65535));
		expr_buf.delete();
		add_tok(K_LIT, pos);
		repeat (20) begin
			add_tok(K_CAT, pos);
			add_tok(K_LIT, pos);
		end
		expr_buf[$].expr_end = 1'b1;
		hold_left = 300;
		send_buf();
		drop_valid();
	endtask

	// Mostly well-formed expressions, some damaged ones, some raw noise.
	task automatic test_random_mix(input int n_items);
		int first;
		int pick;
		first = tokens_sent;
		while (tokens_sent - first < n_items) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				// mostly short expressions, now and then a long one
				build_expression(($urandom_range(9) == 0) ? $urandom_range(12, 30)
					: $urandom_range(1, 8), ($urandom_range(7) == 0) ? 12 : 3);
				if (pick >= 70)
					break_expression();
				send_buf();
			end else begin
				repeat ($urandom_range(1, 4))
					send_token(mk(KIND_W'($urandom_range(7)), LIT_W'($urandom_range(255)),
						POS_W'($urandom_range(65535)), $urandom_range(3) == 0));
			end
		end
		drop_valid();
	endtask

	// ------------------------------------------------------------------------
	// Result sink: random ready, or held low while hold_left runs down
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Every accepted result request is checked against the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.kind     = res_ch.emitted_kind;
			got.literal  = res_ch.emitted_literal;
			got.position = res_ch.emitted_position;
			got.present  = res_ch.token_present;
			got.err      = res_ch.error_code;
			got.done     = res_ch.expression_done;
			got.last     = res_ch.run_last;
			if (postfix_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result kind=%0d lit=%02h pos=%04h", $realtime,
						got.kind, got.literal, got.position);
				mismatches++;
			end else begin
				want = postfix_q.pop_front();
				if (got.kind !== want.kind || got.literal !== want.literal ||
						got.position !== want.position || got.present !== want.present ||
						got.err !== want.err || got.done !== want.done ||
						got.last !== want.last) begin
					if (mismatches < 10) begin
						$display("%0t: mismatch expected kind=%0d lit=%02h pos=%04h",
							$realtime, want.kind, want.literal, want.position,
							" tok=%0d err=%0d done=%0d last=%0d",
							want.present, want.err, want.done, want.last);
						$display("%0t:          actual   kind=%0d lit=%02h pos=%04h",
							$realtime, got.kind, got.literal, got.position,
							" tok=%0d err=%0d done=%0d last=%0d",
							got.present, got.err, got.done, got.last);
					end
					mismatches++;
				end
			end
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		tok_ch.valid = 1'b0;
		tok_ch.token_kind = '0;
		tok_ch.literal_byte = '0;
		tok_ch.source_position = '0;
		tok_ch.expression_end = 1'b0;
		res_ch.ready = 1'b0;
		hold_left = 0;
		mismatches = 0;
		tokens_sent = 0;
		stack_fill = 0;
		skip_mode = 1'b0;
		src_idle_pct = 21;
		snk_idle_pct = 60;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_deep_nesting();

		src_idle_pct = 60;
		snk_idle_pct = 21;
		test_backpressure();
		test_random_mix(75);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_mix(75);

		// drain, then give a full stack flush time to show up stray results
		while (postfix_q.size() > 0)
			@(posedge clk);
		repeat (3 * STACK_DEPTH) @(posedge clk);
		if (mismatches == 0 && postfix_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/ri2p_pkg.sv
rtl/core/ri2p_if.sv
rtl/core/ri2p_stack_mem.sv
rtl/core/ri2p_out_reg.sv
rtl/core/regex_infix_to_postfix.sv
dv/tb.sv
